// File: rtl/mstt_pkg.sv
`timescale 1ns / 1ps

package mstt_pkg;

  // Default number of timer slots
  localparam int TIMER_SLOTS_DEF = 16;

  // Value of the id counter after reset
  localparam logic [31:0] IDENT_RESET = 32'd1;

  // Input actions
  typedef enum logic [1:0] {
    ACT_ONESHOT  = 2'd0,
    ACT_PERIODIC = 2'd1,
    ACT_CLEAR    = 2'd2,
    ACT_PROCESS  = 2'd3
  } action_t;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_CREATED = 3'd0,
    KIND_FULL    = 3'd1,
    KIND_CLEARED = 3'd2,
    KIND_FIRED   = 3'd3,
    KIND_DONE    = 3'd4
  } kind_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CREATE,
    ST_CLEAR,
    ST_SCAN,
    ST_FINAL
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_in;       // capture the input transaction
    logic idx_rst;       // restart slot index at zero
    logic idx_inc;       // move to the next slot
    logic create;        // allocate a slot (or report full) and emit result
    logic clear_hit;     // free the current slot
    logic fire;          // emit fired result and reschedule or free
    logic track_active;  // note the current slot's active bit for process done
    logic emit_final;    // emit clear done / process done
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
    logic idx_last;  // current slot is the last one
    logic match;     // current slot is active and its id matches
    logic due;       // current slot is active and its deadline has passed
  } dp_sts_t;

endpackage

// File: rtl/mstt_ctrl.sv
`timescale 1ns / 1ps

module mstt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        action,
  input  mstt_pkg::dp_sts_t sts,
  output mstt_pkg::dp_cmd_t cmd
);
  import mstt_pkg::*;

  state_t state, state_next;
  action_t act_in;

  assign act_in = action_t'(action);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          cmd.idx_rst = 1'b1;
          unique case (act_in)
            ACT_ONESHOT, ACT_PERIODIC: state_next = ST_CREATE;
            ACT_CLEAR:                 state_next = ST_CLEAR;
            ACT_PROCESS:               state_next = ST_SCAN;
            default:                   state_next = ST_SCAN;
          endcase
        end
      end
      ST_CREATE: begin
        if (sts.out_free) begin
          cmd.create = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        priority if (sts.match) begin
          cmd.clear_hit = 1'b1;
          state_next    = ST_FINAL;
        end else if (sts.idx_last) begin
          state_next = ST_FINAL;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_SCAN: begin
        cmd.track_active = 1'b1;
        // a due slot waits here until the output register frees up
        if (!sts.due || sts.out_free) begin
          cmd.fire = sts.due;
          if (sts.idx_last) begin
            state_next = ST_FINAL;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      ST_FINAL: begin
        if (sts.out_free) begin
          cmd.emit_final = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/mstt_datapath.sv
`timescale 1ns / 1ps

module mstt_datapath #(
  parameter int TIMER_SLOTS = mstt_pkg::TIMER_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        action,
  input  logic [31:0]       now_ms,
  input  logic [31:0]       delay_count,
  input  logic [31:0]       callback_handle,
  input  logic [31:0]       timer_id,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        kind,
  output logic [31:0]       result_id,
  output logic [31:0]       fired_handle,
  output logic              any_active,
  output logic              last,
  input  mstt_pkg::dp_cmd_t cmd,
  output mstt_pkg::dp_sts_t sts
);
  import mstt_pkg::*;

  localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(TIMER_SLOTS - 1);

  // Captured transaction
  action_t     act_q;
  logic [31:0] now_q;
  logic [31:0] delay_q;
  logic [31:0] handle_q;
  logic [31:0] id_q;

  // Slot state
  logic [TIMER_SLOTS-1:0] active;
  logic [31:0]            next_ident;
  logic [31:0]            ident_mem    [TIMER_SLOTS];
  logic [31:0]            handle_mem   [TIMER_SLOTS];
  logic [31:0]            deadline_mem [TIMER_SLOTS];
  logic [31:0]            period_mem   [TIMER_SLOTS];
  logic [31:0]            ident_rd;
  logic [31:0]            handle_rd;
  logic [31:0]            deadline_rd;
  logic [31:0]            period_rd;

  // Scan control
  logic [IW-1:0] idx;
  logic [IW-1:0] rd_addr;
  logic          any_seen;

  // Lookup helpers
  logic          free_found;
  logic [IW-1:0] free_idx;
  logic          active_cur;
  logic [31:0]   elapsed;
  logic          out_free;
  logic          dl_we;
  logic [IW-1:0] dl_waddr;
  logic [31:0]   dl_wdata;
  logic          period_nz;

  // Capture input transaction
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_q    <= action_t'(action);
      now_q    <= now_ms;
      delay_q  <= delay_count;
      handle_q <= callback_handle;
      id_q     <= timer_id;
    end
  end

  // Lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  // Read address runs one slot ahead of the index so data lines up
  always_comb begin
    priority if (cmd.idx_rst) begin
      rd_addr = '0;
    end else if (cmd.idx_inc) begin
      rd_addr = idx + 1'b1;
    end else begin
      rd_addr = idx;
    end
  end

  // Slot index
  always_ff @(posedge clk) begin
    idx <= rd_addr;
  end

  // Status toward controller
  assign active_cur   = active[idx];
  assign elapsed      = now_q - deadline_rd;
  assign out_free     = !out_valid || !out_stall;
  assign period_nz    = (period_rd != 32'd0);
  assign sts.out_free = out_free;
  assign sts.idx_last = (idx == LAST_IDX);
  assign sts.match    = active_cur && (ident_rd == id_q);
  assign sts.due      = active_cur && !elapsed[31];

  // Deadline write port: create or periodic reschedule
  always_comb begin
    dl_we    = 1'b0;
    dl_waddr = idx;
    dl_wdata = now_q + period_rd;
    if (cmd.create && free_found) begin
      dl_we    = 1'b1;
      dl_waddr = free_idx;
      dl_wdata = now_q + delay_q;
    end else if (cmd.fire && period_nz) begin
      dl_we = 1'b1;
    end
  end

  // Slot memories, registered read
  always_ff @(posedge clk) begin
    if (cmd.create && free_found) begin
      ident_mem[free_idx]  <= next_ident;
      handle_mem[free_idx] <= handle_q;
      period_mem[free_idx] <= (act_q == ACT_PERIODIC) ? delay_q : 32'd0;
    end
    if (dl_we) begin
      deadline_mem[dl_waddr] <= dl_wdata;
    end
    ident_rd    <= ident_mem[rd_addr];
    handle_rd   <= handle_mem[rd_addr];
    deadline_rd <= deadline_mem[rd_addr];
    period_rd   <= period_mem[rd_addr];
  end

  // Active bits and id counter
  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= '0;
      next_ident <= IDENT_RESET;
    end else begin
      if (cmd.create && free_found) begin
        active[free_idx] <= 1'b1;
        next_ident       <= next_ident + 32'd1;
      end
      if (cmd.clear_hit || (cmd.fire && !period_nz)) begin
        active[idx] <= 1'b0;
      end
    end
  end

  // Any-active flag for process done
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      any_seen <= 1'b0;
    end else if (cmd.track_active && active_cur) begin
      any_seen <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.create || cmd.fire || cmd.emit_final) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.create) begin
      kind         <= free_found ? KIND_CREATED : KIND_FULL;
      result_id    <= free_found ? next_ident : 32'd0;
      fired_handle <= 32'd0;
      any_active   <= 1'b0;
      last         <= 1'b1;
    end else if (cmd.fire) begin
      kind         <= KIND_FIRED;
      result_id    <= ident_rd;
      fired_handle <= handle_rd;
      any_active   <= 1'b0;
      last         <= 1'b0;
    end else if (cmd.emit_final) begin
      kind         <= (act_q == ACT_CLEAR) ? KIND_CLEARED : KIND_DONE;
      result_id    <= 32'd0;
      fired_handle <= 32'd0;
      any_active   <= (act_q == ACT_PROCESS) ? any_seen : 1'b0;
      last         <= 1'b1;
    end else begin
      kind         <= kind;
    end
  end

endmodule

// File: rtl/multi_slot_software_timer_table_unit.sv
`timescale 1ns / 1ps

// Software timer table: TIMER_SLOTS slots of one-shot or periodic timers.
// One input transaction at a time. A create captures the transaction, then
// allocates into the lowest free slot through a priority search, and gives
// one result. A clear walks the slots one per cycle until the id matches.
// A process walks every slot, one per cycle through the registered slot
// memories while the output is not stalled, and gives one fired result per
// expired timer then a done result; a due slot waits while the output
// register is still held. The output register lets the next transaction be
// accepted while the final result of the previous one waits to be taken.

module multi_slot_software_timer_table_unit #(
  parameter int TIMER_SLOTS = mstt_pkg::TIMER_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [31:0] now_ms,
  input  logic [31:0] delay_count,
  input  logic [31:0] callback_handle,
  input  logic [31:0] timer_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [31:0] result_id,
  output logic [31:0] fired_handle,
  output logic        any_active,
  output logic        last
);
  import mstt_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  mstt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .sts      (sts),
    .cmd      (cmd)
  );

  mstt_datapath #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .action          (action),
    .now_ms          (now_ms),
    .delay_count     (delay_count),
    .callback_handle (callback_handle),
    .timer_id        (timer_id),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .kind            (kind),
    .result_id       (result_id),
    .fired_handle    (fired_handle),
    .any_active      (any_active),
    .last            (last),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule
